// ===== sv/mandelbrot_escape_time_pixel_unit_defines.svh =====
// Assertion macros for the Mandelbrot pixel unit RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define MET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/met_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the Mandelbrot pixel unit.
// No dependencies; used by every module of the block.
package met_pkg;

  // Algorithm constants
  localparam int MAX_ITERATIONS = 500;
  localparam int FRACTION_BITS  = 28;
  localparam int REG_FRAC       = 28;

  // Field widths
  localparam int GRID_W     = 8;
  localparam int STEP_W     = 31;
  localparam int OFFS_W     = 32;
  localparam int LEVEL_W    = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Internal fixed-point widths
  localparam int Q_W     = FRACTION_BITS + 4;
  localparam int REG_SHL = (FRACTION_BITS >= REG_FRAC) ? FRACTION_BITS - REG_FRAC : 0;
  localparam int REG_SHR = (FRACTION_BITS < REG_FRAC) ? REG_FRAC - FRACTION_BITS : 0;
  localparam int REG_W   = OFFS_W + REG_SHL;
  localparam int D_W     = GRID_W + 2;
  localparam int CP_W    = D_W + REG_W;
  localparam int PROD_W  = 2 * Q_W;
  localparam int SQ_W    = PROD_W - FRACTION_BITS;
  localparam int SUM_W   = SQ_W + 1;
  localparam int WIDE_W  = ((CP_W > PROD_W) ? CP_W : PROD_W) + 2;

  // Iteration counter and divider widths
  localparam int CNT_W     = $clog2(MAX_ITERATIONS + 1);
  localparam int DIV_RW    = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;
  localparam int DIV_DW    = DIV_RW + LEVEL_W;
  localparam int DIV_CELLS = DIV_DW;

  localparam logic [CNT_W-1:0]   ITER_LIMIT = CNT_W'(MAX_ITERATIONS);
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = {LEVEL_W{1'b1}};

  // Saturation bounds and escape radius squared (4.0)
  localparam logic signed [WIDE_W-1:0] Q_HI = {{(WIDE_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] Q_LO = {{(WIDE_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] ESCAPE_LIMIT =
    {{(SUM_W-FRACTION_BITS-3){1'b0}}, 3'b100, {FRACTION_BITS{1'b0}}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET   = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [GRID_W-1:0]        GRID_RESET = 8'd255;
  localparam logic [STEP_W-1:0]        STEP_RESET = 31'd4210752;
  localparam logic signed [OFFS_W-1:0] X_RESET    = 32'shF000_0000;
  localparam logic signed [OFFS_W-1:0] Y_RESET    = 32'sh0000_0000;

  // Divider word tags
  localparam logic TAG_SIZE = 1'b0;
  localparam logic TAG_BLUE = 1'b1;

  // One word moving down the divider chain
  typedef struct packed {
    logic              valid;
    logic              tag;
    logic [DIV_RW-1:0] rem;
    logic [DIV_DW-1:0] word;
    logic [DIV_RW-1:0] divisor;
  } div_lane_t;

  // Sequencer controls into the iteration core
  typedef struct packed {
    logic prod;
    logic map;
    logic square;
    logic update;
  } core_ctl_t;

  // Iteration core status back to the sequencer
  typedef struct packed {
    logic             finish;
    logic [CNT_W-1:0] count;
  } core_stat_t;

  // Clamp a wide value to the signed Q4.F range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    c = v;
    if (v > Q_HI) c = Q_HI;
    if (v < Q_LO) c = Q_LO;
    return c[Q_W-1:0];
  endfunction

endpackage

// ===== sv/met_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring-division cell: settles one quotient bit per word.
// Depends on met_pkg for the lane structure and widths.
module met_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  met_pkg::div_lane_t lane_in,
  output met_pkg::div_lane_t lane_out
);

  logic [met_pkg::DIV_RW:0]   trial;
  logic [met_pkg::DIV_RW:0]   diff;
  logic                       fits;
  logic [met_pkg::DIV_RW-1:0] rem_next;
  logic [met_pkg::DIV_DW-1:0] word_next;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial     = {lane_in.rem, lane_in.word[met_pkg::DIV_DW-1]};
    diff      = trial - {1'b0, lane_in.divisor};
    fits      = (trial >= {1'b0, lane_in.divisor});
    rem_next  = fits ? diff[met_pkg::DIV_RW-1:0] : trial[met_pkg::DIV_RW-1:0];
    word_next = {lane_in.word[met_pkg::DIV_DW-2:0], fits};
  end

  // Hand the word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out.valid <= lane_in.valid;
    end
    lane_out.tag     <= lane_in.tag;
    lane_out.rem     <= rem_next;
    lane_out.word    <= word_next;
    lane_out.divisor <= lane_in.divisor;
  end

endmodule

// ===== sv/met_div_chain.sv =====
`timescale 1ns / 1ps
// Pipelined divider: a row of met_div_cell, one quotient bit per cell.
// Depends on met_pkg and met_div_cell.
module met_div_chain (
  input  logic               clk,
  input  logic               rst,
  input  met_pkg::div_lane_t head,
  output met_pkg::div_lane_t tail
);

  met_pkg::div_lane_t lane [0:met_pkg::DIV_CELLS];

  assign lane[0] = head;

  // Build the row of cells
  genvar i;
  generate
    for (i = 0; i < met_pkg::DIV_CELLS; i++) begin : g_cell
      met_div_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .lane_in  (lane[i]),
        .lane_out (lane[i+1])
      );
    end
  endgenerate

  assign tail = lane[met_pkg::DIV_CELLS];

endmodule

// ===== sv/met_iter_core.sv =====
`timescale 1ns / 1ps
// Point mapping and z = z*z + c datapath, one step per sequencer control.
// Depends on met_pkg for widths, saturation and control structures.
module met_iter_core (
  input  logic                               clk,
  input  logic                               rst,
  input  met_pkg::core_ctl_t                 ctl,
  input  logic [met_pkg::GRID_W-1:0]         row,
  input  logic [met_pkg::GRID_W-1:0]         col,
  input  logic [met_pkg::GRID_W-1:0]         grid_size,
  input  logic [met_pkg::STEP_W-1:0]         pixel_step,
  input  logic signed [met_pkg::OFFS_W-1:0]  x_offset,
  input  logic signed [met_pkg::OFFS_W-1:0]  y_offset,
  output met_pkg::core_stat_t                stat
);

  logic signed [met_pkg::D_W-1:0]    d_col;
  logic signed [met_pkg::D_W-1:0]    d_row;
  logic signed [met_pkg::REG_W-1:0]  step_q;
  logic signed [met_pkg::REG_W-1:0]  xoff_q;
  logic signed [met_pkg::REG_W-1:0]  yoff_q;
  logic signed [met_pkg::CP_W-1:0]   prod_re;
  logic signed [met_pkg::CP_W-1:0]   prod_im;
  logic signed [met_pkg::Q_W-1:0]    cr;
  logic signed [met_pkg::Q_W-1:0]    ci;
  logic signed [met_pkg::Q_W-1:0]    x;
  logic signed [met_pkg::Q_W-1:0]    y;
  logic signed [met_pkg::PROD_W-1:0] p_xx;
  logic signed [met_pkg::PROD_W-1:0] p_yy;
  logic signed [met_pkg::PROD_W-1:0] p_xy;
  logic signed [met_pkg::SQ_W-1:0]   xx;
  logic signed [met_pkg::SQ_W-1:0]   yy;
  logic signed [met_pkg::SQ_W-1:0]   xy;
  logic signed [met_pkg::SUM_W-1:0]  mag2;
  logic signed [met_pkg::Q_W-1:0]    re_diff;
  logic signed [met_pkg::Q_W-1:0]    im_twice;
  logic signed [met_pkg::Q_W-1:0]    x_next;
  logic signed [met_pkg::Q_W-1:0]    y_next;
  logic [met_pkg::CNT_W-1:0]         count;

  // Offset from grid center in half pixels, registers in internal format
  assign d_col  = $signed({1'b0, col, 1'b0}) - $signed({2'b00, grid_size});
  assign d_row  = $signed({1'b0, row, 1'b0}) - $signed({2'b00, grid_size});
  assign step_q = ($signed(met_pkg::REG_W'({1'b0, pixel_step})) <<< met_pkg::REG_SHL)
                  >>> met_pkg::REG_SHR;
  assign xoff_q = (met_pkg::REG_W'(x_offset) <<< met_pkg::REG_SHL) >>> met_pkg::REG_SHR;
  assign yoff_q = (met_pkg::REG_W'(y_offset) <<< met_pkg::REG_SHL) >>> met_pkg::REG_SHR;

  // Full products of the current iterate
  assign p_xx = x * x;
  assign p_yy = y * y;
  assign p_xy = x * y;

  // Escape test and next iterate from the registered squares
  always_comb begin
    mag2     = met_pkg::SUM_W'(xx) + met_pkg::SUM_W'(yy);
    re_diff  = met_pkg::sat_q(met_pkg::WIDE_W'(xx) - met_pkg::WIDE_W'(yy));
    im_twice = met_pkg::sat_q(met_pkg::WIDE_W'(xy) <<< 1);
    x_next   = met_pkg::sat_q(met_pkg::WIDE_W'(re_diff) + met_pkg::WIDE_W'(cr));
    y_next   = met_pkg::sat_q(met_pkg::WIDE_W'(im_twice) + met_pkg::WIDE_W'(ci));
  end

  // Coordinate products
  always_ff @(posedge clk) begin
    if (ctl.prod) begin
      prod_re <= met_pkg::CP_W'(d_col) * met_pkg::CP_W'(step_q);
      prod_im <= met_pkg::CP_W'(d_row) * met_pkg::CP_W'(step_q);
    end
  end

  // Point c, floor-halved and offset; iterate and squares
  always_ff @(posedge clk) begin
    if (ctl.map) begin
      cr <= met_pkg::sat_q(met_pkg::WIDE_W'(prod_re >>> 1) + met_pkg::WIDE_W'(xoff_q));
      ci <= met_pkg::sat_q(met_pkg::WIDE_W'(prod_im >>> 1) + met_pkg::WIDE_W'(yoff_q));
      x  <= '0;
      y  <= '0;
    end else if (ctl.update) begin
      x <= x_next;
      y <= y_next;
    end
    if (ctl.square) begin
      xx <= $signed(p_xx[met_pkg::PROD_W-1:met_pkg::FRACTION_BITS]);
      yy <= $signed(p_yy[met_pkg::PROD_W-1:met_pkg::FRACTION_BITS]);
      xy <= $signed(p_xy[met_pkg::PROD_W-1:met_pkg::FRACTION_BITS]);
    end
  end

  // Iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.map) begin
      count <= '0;
    end else if (ctl.update) begin
      count <= count + met_pkg::CNT_W'(1);
    end
  end

  assign stat.count  = count;
  assign stat.finish = (mag2 > met_pkg::ESCAPE_LIMIT) || (count >= met_pkg::ITER_LIMIT);

endmodule

// ===== sv/mandelbrot_escape_time_pixel_unit.sv =====
`timescale 1ns / 1ps
// Per pixel: product and map states, then alternating square and update states until
// escape or the limit, escape_count (1..500), then drain; the 17-cell divider row adds
// its depth once per pixel. One pixel at a time: start is taken again in the cycle that
// done shows. done lasts one cycle; the receiver cannot stall.
// Synchronous reset restores the register reset values and idles the block.
`include "mandelbrot_escape_time_pixel_unit_defines.svh"
module mandelbrot_escape_time_pixel_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [met_pkg::GRID_W-1:0]        pixel_row,
  input  logic [met_pkg::GRID_W-1:0]        pixel_col,
  output logic                              done,
  output logic [met_pkg::CNT_W-1:0]         escape_count,
  output logic                              inside_set,
  output logic [met_pkg::LEVEL_W-1:0]       red_level,
  output logic [met_pkg::LEVEL_W-1:0]       green_level,
  output logic [met_pkg::LEVEL_W-1:0]       blue_level,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [met_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PROD   = 3'd1;
  localparam logic [2:0] ST_MAP    = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;

  logic [2:0]                         state;
  logic [2:0]                         state_next;
  logic [met_pkg::GRID_W-1:0]         grid_size;
  logic [met_pkg::STEP_W-1:0]         pixel_step;
  logic signed [met_pkg::OFFS_W-1:0]  x_offset;
  logic signed [met_pkg::OFFS_W-1:0]  y_offset;
  logic [met_pkg::GRID_W-1:0]         row;
  logic [met_pkg::GRID_W-1:0]         col;
  logic [met_pkg::LEVEL_W-1:0]        level_div;
  logic                               accept;
  logic                               launch_blue;
  logic                               tail_size;
  logic                               tail_blue;
  logic                               limit_hit;
  logic [2*met_pkg::LEVEL_W-1:0]      red_raw;
  logic [2*met_pkg::LEVEL_W-1:0]      green_raw;
  met_pkg::core_ctl_t                 ctl;
  met_pkg::core_stat_t                stat;
  met_pkg::div_lane_t                 head;
  met_pkg::div_lane_t                 tail;

  assign busy        = (state != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign accept      = start && !busy;
  assign launch_blue = (state == ST_UPDATE) && stat.finish;
  assign tail_size   = tail.valid && (tail.tag == met_pkg::TAG_SIZE);
  assign tail_blue   = tail.valid && (tail.tag == met_pkg::TAG_BLUE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= met_pkg::GRID_RESET;
      pixel_step <= met_pkg::STEP_RESET;
      x_offset   <= met_pkg::X_RESET;
      y_offset   <= met_pkg::Y_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        met_pkg::REG_GRID_SIZE:  grid_size  <= cfg_data[met_pkg::GRID_W-1:0];
        met_pkg::REG_PIXEL_STEP: pixel_step <= cfg_data[met_pkg::STEP_W-1:0];
        met_pkg::REG_X_OFFSET:   x_offset   <= $signed(cfg_data[met_pkg::OFFS_W-1:0]);
        met_pkg::REG_Y_OFFSET:   y_offset   <= $signed(cfg_data[met_pkg::OFFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_PROD;
      end
      ST_PROD: begin
        ctl.prod   = 1'b1;
        state_next = ST_MAP;
      end
      ST_MAP: begin
        ctl.map    = 1'b1;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        ctl.square = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat.finish) begin
          state_next = ST_DRAIN;
        end else begin
          ctl.update = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_DRAIN: begin
        if (tail_blue) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the pixel position
  always_ff @(posedge clk) begin
    if (accept) begin
      row <= pixel_row;
      col <= pixel_col;
    end
  end

  // Feed the divider: 255 div size at start, count*255 div limit at the end
  always_comb begin
    head = '0;
    if (accept) begin
      head.valid   = 1'b1;
      head.tag     = met_pkg::TAG_SIZE;
      head.word    = met_pkg::DIV_DW'(met_pkg::LEVEL_FULL);
      head.divisor = met_pkg::DIV_RW'(grid_size);
    end else if (launch_blue) begin
      head.valid   = 1'b1;
      head.tag     = met_pkg::TAG_BLUE;
      head.word    = met_pkg::DIV_DW'({stat.count, {met_pkg::LEVEL_W{1'b0}}})
                   - met_pkg::DIV_DW'(stat.count);
      head.divisor = met_pkg::DIV_RW'(met_pkg::ITER_LIMIT);
    end
  end

  met_div_chain u_div_chain (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .tail (tail)
  );

  met_iter_core u_iter_core (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .row        (row),
    .col        (col),
    .grid_size  (grid_size),
    .pixel_step (pixel_step),
    .x_offset   (x_offset),
    .y_offset   (y_offset),
    .stat       (stat)
  );

  // Hold the color divisor; zero size gives zero
  always_ff @(posedge clk) begin
    if (tail_size) begin
      level_div <= (grid_size == '0) ? '0 : tail.word[met_pkg::LEVEL_W-1:0];
    end
  end

  // Color levels, clamped at full scale
  assign limit_hit = (stat.count >= met_pkg::ITER_LIMIT);
  assign red_raw   = (2*met_pkg::LEVEL_W)'(row) * (2*met_pkg::LEVEL_W)'(level_div);
  assign green_raw = (2*met_pkg::LEVEL_W)'(col) * (2*met_pkg::LEVEL_W)'(level_div);

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DRAIN) && tail_blue;
    end
    if ((state == ST_DRAIN) && tail_blue) begin
      escape_count <= stat.count;
      inside_set   <= limit_hit;
      if (limit_hit) begin
        red_level   <= '0;
        green_level <= '0;
        blue_level  <= '0;
      end else begin
        red_level   <= (red_raw > (2*met_pkg::LEVEL_W)'(met_pkg::LEVEL_FULL)) ?
                       met_pkg::LEVEL_FULL : red_raw[met_pkg::LEVEL_W-1:0];
        green_level <= (green_raw > (2*met_pkg::LEVEL_W)'(met_pkg::LEVEL_FULL)) ?
                       met_pkg::LEVEL_FULL : green_raw[met_pkg::LEVEL_W-1:0];
        blue_level  <= tail.word[met_pkg::LEVEL_W-1:0];
      end
    end
  end

  // Checks
  `MET_ASSERT_NOW(a_done_from_drain, done, $past(state) == ST_DRAIN,
                  "result word without drain")
  `MET_ASSERT_NOW(a_inside_flag, done,
                  inside_set == (escape_count == met_pkg::ITER_LIMIT),
                  "inside flag disagrees with count")
  `MET_ASSERT_NOW(a_count_bound, 1'b1, stat.count <= met_pkg::ITER_LIMIT,
                  "iteration count past limit")
  `MET_ASSERT_NOW(a_blue_in_drain, tail_blue, state == ST_DRAIN,
                  "blue quotient outside drain")
  `MET_ASSERT_NEXT(a_start_to_prod, accept, state == ST_PROD,
                   "accepted word did not start")

endmodule

// ===== verif/mandelbrot_escape_time_pixel_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Mandelbrot escape-time pixel unit.
// Depends on met_pkg and mandelbrot_escape_time_pixel_unit; reads no files.
module mandelbrot_escape_time_pixel_unit_test;

  localparam int FB          = met_pkg::FRACTION_BITS;
  localparam int ITER_CAP    = met_pkg::MAX_ITERATIONS;
  localparam int LEVEL_TOP   = 255;
  localparam int IDLE_PCT    = 18;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int TAIL_CYCLES = 1100;
  localparam int PLAN_ROWS   = 35;

  localparam longint Q_MAX       = (longint'(1) <<< (FB + 3)) - 1;
  localparam longint Q_MIN       = -Q_MAX - 1;
  localparam longint RADIUS_SQ   = longint'(4) <<< FB;
  localparam longint SPAN_OF_FOUR = longint'(4) <<< met_pkg::REG_FRAC;

  // Register indexes past the end of the map; writes there are dropped
  localparam logic [met_pkg::CFG_IDX_W-1:0] REG_SPARE_LOW = met_pkg::CFG_IDX_W'(4);
  localparam logic [met_pkg::CFG_IDX_W-1:0] REG_SPARE_TOP = '1;

  typedef struct packed {
    logic [met_pkg::CNT_W-1:0]   count;
    logic                        in_set;
    logic [met_pkg::LEVEL_W-1:0] red;
    logic [met_pkg::LEVEL_W-1:0] green;
    logic [met_pkg::LEVEL_W-1:0] blue;
  } pixel_result_t;

  // Results that follow directly from the register values
  localparam pixel_result_t ESCAPE_FIRST_DARK =
    '{count: 1, in_set: 0, red: 0, green: 0, blue: 0};
  localparam pixel_result_t ESCAPE_FIRST_FULL =
    '{count: 1, in_set: 0, red: LEVEL_TOP, green: LEVEL_TOP, blue: 0};
  localparam pixel_result_t HELD_IN_SET =
    '{count: ITER_CAP, in_set: 1, red: 0, green: 0, blue: 0};
  localparam pixel_result_t FROM_MODEL = '0;

  typedef enum logic {PLAN_WRITE, PLAN_PIXEL} plan_kind_t;

  typedef struct {
    plan_kind_t                    kind;
    logic [met_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   data;
    logic [met_pkg::GRID_W-1:0]    row;
    logic [met_pkg::GRID_W-1:0]    col;
    bit                            typed;
    pixel_result_t                 want;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [met_pkg::GRID_W-1:0] pixel_row = '0;
  logic [met_pkg::GRID_W-1:0] pixel_col = '0;
  logic done;
  logic [met_pkg::CNT_W-1:0] escape_count;
  logic inside_set;
  logic [met_pkg::LEVEL_W-1:0] red_level;
  logic [met_pkg::LEVEL_W-1:0] green_level;
  logic [met_pkg::LEVEL_W-1:0] blue_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [met_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [met_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the register file
  logic [met_pkg::GRID_W-1:0]        grid_size_q  = met_pkg::GRID_RESET;
  logic [met_pkg::STEP_W-1:0]        pixel_step_q = met_pkg::STEP_RESET;
  logic signed [met_pkg::OFFS_W-1:0] x_offset_q   = met_pkg::X_RESET;
  logic signed [met_pkg::OFFS_W-1:0] y_offset_q   = met_pkg::Y_RESET;

  pixel_result_t pixel_pending[$];
  int unsigned fault_count = 0;
  int unsigned sender_idle_pct = IDLE_PCT;

  // Directed walk: extremes, every register, zero size and step, dropped indexes
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{PLAN_PIXEL, '0, '0, 8'd0,   8'd0,   1'b1, ESCAPE_FIRST_DARK},
    '{PLAN_PIXEL, '0, '0, 8'd127, 8'd127, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd254, 8'd254, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd255, 8'd255, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_GRID_SIZE, 32'hFFFF_FF00, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd200, 8'd17,  1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_GRID_SIZE, 32'h0000_0001, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd1,   8'd1,   1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd0,   8'd255, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_PIXEL_STEP, 32'h0000_0000, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_X_OFFSET, 32'h0000_0000, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_Y_OFFSET, 32'h0000_0000, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd255, 8'd0,   1'b1, HELD_IN_SET},
    '{PLAN_WRITE, met_pkg::REG_X_OFFSET, 32'h7FFF_FFFF, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd3,   8'd5,   1'b1, ESCAPE_FIRST_FULL},
    '{PLAN_WRITE, met_pkg::REG_X_OFFSET, 32'h8000_0000, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_Y_OFFSET, 32'h7FFF_FFFF, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd0,   8'd0,   1'b1, ESCAPE_FIRST_DARK},
    '{PLAN_WRITE, met_pkg::REG_Y_OFFSET, 32'h8000_0000, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd255, 8'd128, 1'b1, ESCAPE_FIRST_FULL},
    '{PLAN_WRITE, met_pkg::REG_PIXEL_STEP, 32'hFFFF_FFFF, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_GRID_SIZE, 32'h0000_00FF, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_X_OFFSET, 32'h0000_0000, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_Y_OFFSET, 32'h0000_0000, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd0,   8'd0,   1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd255, 8'd255, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd128, 8'd127, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, REG_SPARE_LOW, 32'hDEAD_BEEF, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, REG_SPARE_TOP, 32'hFFFF_FFFF, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd64,  8'd200, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_GRID_SIZE, 32'hABCD_EFFF, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_PIXEL_STEP, 32'd4210752, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_X_OFFSET, 32'hF000_0000, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_WRITE, met_pkg::REG_Y_OFFSET, 32'h0000_0000, '0, '0, 1'b0, FROM_MODEL},
    '{PLAN_PIXEL, '0, '0, 8'd128, 8'd64,  1'b0, FROM_MODEL}
  };

  mandelbrot_escape_time_pixel_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp to the signed Q4.F range
  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Q4.28 register value to Q4.F, floor on a right shift
  function automatic longint reg_to_fixed(input longint v);
    return (v <<< met_pkg::REG_SHL) >>> met_pkg::REG_SHR;
  endfunction

  // Fixed-point product rounded toward minus infinity
  function automatic longint fixed_mul(input longint a, input longint b);
    return (a * b) >>> FB;
  endfunction

  // Grid index to one coordinate of c
  function automatic longint map_axis(input logic [met_pkg::GRID_W-1:0] idx,
                                      input logic signed [met_pkg::OFFS_W-1:0] off);
    longint span;
    span = (2 * longint'(idx) - longint'(grid_size_q)) * reg_to_fixed(longint'(pixel_step_q));
    return clamp_q((span >>> 1) + reg_to_fixed(longint'(off)));
  endfunction

  function automatic int color_level(input logic [met_pkg::GRID_W-1:0] idx, input int div);
    int v;
    v = int'(idx) * div;
    return (v > LEVEL_TOP) ? LEVEL_TOP : v;
  endfunction

  // Escape count and colors of one pixel under the current registers
  function automatic pixel_result_t predict_pixel(input logic [met_pkg::GRID_W-1:0] row,
                                                  input logic [met_pkg::GRID_W-1:0] col);
    longint cr, ci, x, y, xx, yy, xy;
    int n, div;
    pixel_result_t res;
    cr = map_axis(col, x_offset_q);
    ci = map_axis(row, y_offset_q);
    x = 0;
    y = 0;
    for (n = 0; n < ITER_CAP; n++) begin
      xx = fixed_mul(x, x);
      yy = fixed_mul(y, y);
      if (xx + yy > RADIUS_SQ) break;
      xy = fixed_mul(x, y);
      x = clamp_q(clamp_q(xx - yy) + cr);
      y = clamp_q(clamp_q(2 * xy) + ci);
    end
    div = (grid_size_q != 0) ? LEVEL_TOP / int'(grid_size_q) : 0;
    res = '0;
    res.count = n[met_pkg::CNT_W-1:0];
    res.in_set = (n >= ITER_CAP);
    if (!res.in_set) begin
      res.red = met_pkg::LEVEL_W'(color_level(row, div));
      res.green = met_pkg::LEVEL_W'(color_level(col, div));
      res.blue = met_pkg::LEVEL_W'((n * LEVEL_TOP) / ITER_CAP);
    end
    return res;
  endfunction

  function automatic void apply_register(input logic [met_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [31:0] value);
    case (idx)
      met_pkg::REG_GRID_SIZE:  grid_size_q = value[met_pkg::GRID_W-1:0];
      met_pkg::REG_PIXEL_STEP: pixel_step_q = value[met_pkg::STEP_W-1:0];
      met_pkg::REG_X_OFFSET:   x_offset_q = value;
      met_pkg::REG_Y_OFFSET:   y_offset_q = value;
      default: ;
    endcase
  endfunction

  // Drop start and the write strobe, then wait until every pixel is back
  task automatic settle_block();
    if (start) start <= 1'b0;
    if (cfg_valid) cfg_valid <= 1'b0;
    @(negedge clk);
    while (pixel_pending.size() != 0) @(negedge clk);
  endtask

  // One register word; the block is drained first
  task automatic cfg_write(input logic [met_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, value);
    @(negedge clk);
  endtask

  // One pixel word; start may stay high on return for the next word
  task automatic push_pixel(input logic [met_pkg::GRID_W-1:0] row,
                            input logic [met_pkg::GRID_W-1:0] col,
                            input bit typed, input pixel_result_t typed_want);
    bit taken;
    pixel_result_t want;
    taken = 0;
    if (cfg_valid) cfg_valid <= 1'b0;
    pixel_row <= row;
    pixel_col <= col;
    // hold off now and then for a longer stretch
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < 4) begin
      start <= 1'b0;
      repeat ($urandom_range(2, 40)) @(negedge clk);
    end
    while (!taken) begin
      start <= ($urandom_range(0, 99) >= sender_idle_pct);
      @(posedge clk);
      if (start && !busy) begin
        taken = 1;
        want = typed ? typed_want : predict_pixel(row, col);
        pixel_pending = {pixel_pending, want};
      end
      @(negedge clk);
    end
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    pixel_result_t want, got;
    if (!rst && done) begin
      got = {escape_count, inside_set, red_level, green_level, blue_level};
      if (pixel_pending.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: result word with nothing pending: count %0d", $time, escape_count);
      end else begin
        want = pixel_pending.pop_front();
        if (got.count !== want.count || got.in_set !== want.in_set || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: mismatch exp/act count %0d/%0d in_set %0b/%0b red %0d/%0d %s",
                     $time, want.count, got.count, want.in_set, got.in_set, want.red, got.red,
                     $sformatf("green %0d/%0d blue %0d/%0d",
                               want.green, got.green, want.blue, got.blue));
        end
      end
    end
  end

  initial begin
    int phase, k, pause_at, grid, zoom, pick, x_pick, y_pick;
    logic [met_pkg::GRID_W-1:0] row, col;
    logic [met_pkg::STEP_W-1:0] step;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed plan
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == PLAN_WRITE)
        cfg_write(directed_plan[i].index, directed_plan[i].data);
      else
        push_pixel(directed_plan[i].row, directed_plan[i].col,
                   directed_plan[i].typed, directed_plan[i].want);
    end

    // Random phases, each under its own view; the first keeps the reset view
    for (phase = 0; phase < PHASES; phase++) begin
      sender_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
      if (phase != 0) begin
        pick = $urandom_range(0, 11);
        grid = (pick == 0) ? $urandom_range(0, 3) : $urandom_range(8, 255);
        zoom = 1 << $urandom_range(0, 6);
        step = met_pkg::STEP_W'(SPAN_OF_FOUR / (longint'((grid == 0) ? 1 : grid) * zoom));
        if (pick == 1) step = met_pkg::STEP_W'($urandom);
        if (pick == 3) step = '0;
        x_pick = -536870912 + int'($urandom_range(0, 671088640));
        y_pick = -322122547 + int'($urandom_range(0, 644245094));
        if (pick == 2) begin
          x_pick = $urandom;
          y_pick = $urandom;
        end
        cfg_write(met_pkg::REG_GRID_SIZE, {24'($urandom_range(0, 16777215)), grid[7:0]});
        cfg_write(met_pkg::REG_PIXEL_STEP, {1'($urandom_range(0, 1)), step});
        cfg_write(met_pkg::REG_X_OFFSET, x_pick);
        cfg_write(met_pkg::REG_Y_OFFSET, y_pick);
        if ($urandom_range(0, 1))
          cfg_write(met_pkg::CFG_IDX_W'($urandom_range(4, 255)), $urandom);
      end
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // let the block run dry once per phase
        if (k == pause_at) settle_block();
        if (grid_size_q != 0 && $urandom_range(0, 9) != 0) begin
          row = met_pkg::GRID_W'($urandom_range(0, grid_size_q - 1));
          col = met_pkg::GRID_W'($urandom_range(0, grid_size_q - 1));
        end else begin
          row = met_pkg::GRID_W'($urandom_range(0, 255));
          col = met_pkg::GRID_W'($urandom_range(0, 255));
        end
        push_pixel(row, col, 1'b0, FROM_MODEL);
      end
    end

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixel_pending.size() != 0) begin
      fault_count++;
      $display("%0d pixel results never arrived", pixel_pending.size());
    end
    if (fault_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog
  initial begin
    #60ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
